// ----- rtl/core/srl_pkg.sv -----
// shared types and constants for the sorted render list
// holds payload structs, status and operation codes, cell control struct
// no dependencies
`default_nettype none

package srl_pkg;

    // list size and derived widths
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        handle;
        logic signed [15:0] sort_key;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic               entry_valid;
        logic [15:0]        entry_handle;
        logic signed [15:0] entry_key;
        logic [5:0]         entry_count;
        logic               last;
    } t_out;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    // broadcast control from the sequencer to the cell row
    typedef struct packed {
        t_cell_op           mode;
        logic [15:0]        handle;
        logic signed [15:0] key;
        logic [CNT_W-1:0]   count;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/srl_cell.sv -----
// one slot of the sorted list: holds a handle and key, compares against the
// broadcast command and moves data to or from its neighbors
// depends on srl_pkg
`default_nettype none

module srl_cell (
    input  wire                         i_clk,
    input  wire logic [srl_pkg::IDX_W-1:0] i_index,
    input  wire srl_pkg::t_cell_ctl     i_ctl,
    input  wire logic [15:0]            i_left_handle,
    input  wire logic signed [15:0]     i_left_key,
    input  wire logic                   i_left_gt,
    input  wire logic [15:0]            i_right_handle,
    input  wire logic signed [15:0]     i_right_key,
    input  wire logic [15:0]            i_head_handle,
    input  wire logic signed [15:0]     i_head_key,
    input  wire logic                   i_carry,
    output logic [15:0]                 o_handle,
    output logic signed [15:0]          o_key,
    output logic                        o_gt,
    output logic                        o_match,
    output logic                        o_carry
);

    logic [15:0]                r_handle;
    logic signed [15:0]         r_key;
    logic [15:0]                n_handle;
    logic signed [15:0]         n_key;
    logic                       w_valid;
    logic                       w_is_end;
    logic                       w_is_tail;
    logic [srl_pkg::CNT_W-1:0]  w_idx;

    // slot position against the fill count
    assign w_idx     = srl_pkg::CNT_W'(i_index);
    assign w_valid   = w_idx < i_ctl.count;
    assign w_is_end  = w_idx == i_ctl.count;
    assign w_is_tail = (w_idx + srl_pkg::CNT_W'(1)) == i_ctl.count;

    // compares against the command
    assign o_gt    = w_valid && (r_key > i_ctl.key);
    assign o_match = w_valid && (r_handle == i_ctl.handle);
    assign o_carry = i_carry || o_match;

    assign o_handle = r_handle;
    assign o_key    = r_key;

    // next slot content
    always_comb begin
        n_handle = r_handle;
        n_key    = r_key;
        case (i_ctl.mode)
            srl_pkg::CELL_INSERT: begin
                if (i_left_gt) begin
                    n_handle = i_left_handle;
                    n_key    = i_left_key;
                end else if (o_gt || w_is_end) begin
                    n_handle = i_ctl.handle;
                    n_key    = i_ctl.key;
                end
            end
            srl_pkg::CELL_REMOVE: begin
                if (o_carry) begin
                    n_handle = i_right_handle;
                    n_key    = i_right_key;
                end
            end
            srl_pkg::CELL_ROTATE: begin
                if (w_is_tail) begin
                    n_handle = i_head_handle;
                    n_key    = i_head_key;
                end else begin
                    n_handle = i_right_handle;
                    n_key    = i_right_key;
                end
            end
            default: begin
                n_handle = r_handle;
                n_key    = r_key;
            end
        endcase
    end

    // slot storage, no reset
    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_key    <= n_key;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_render_list_top.sv -----
// top level of the sorted render list: command sequencer, result register
// and the row of list cells
// depends on srl_pkg and srl_cell
// insert/remove: the command is registered on accept and the result is registered once the output is free
// read-out: count results, one per cycle while the output is not stalled; the
//   row rotates through cell 0 so the list is back in place after the last one
// an empty read-out gives a single result, marked last and with no entry
// reset clears the fill count, sequencer and result valid; slot contents are not cleared
`default_nettype none

module sorted_render_list_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire srl_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output srl_pkg::t_out       o_out_data
);

    localparam int N = srl_pkg::CAPACITY;

    srl_pkg::t_state              r_state, n_state;
    srl_pkg::t_in                 r_cmd, n_cmd;
    logic [srl_pkg::CNT_W-1:0]    r_count, n_count;
    logic [srl_pkg::CNT_W-1:0]    r_rd, n_rd;
    srl_pkg::t_out                r_out, n_out;
    logic                         r_out_valid, n_out_valid;
    srl_pkg::t_cell_ctl           w_ctl;
    logic                         w_out_free;
    logic                         w_any_match;
    logic                         w_rd_last;

    logic [15:0]                  w_handle [N];
    logic signed [15:0]           w_key    [N];
    logic [N-1:0]                 w_gt;
    logic [N-1:0]                 w_match;
    logic [N-1:0]                 w_carry;

    // cell row
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [15:0]        w_lh;
        logic signed [15:0] w_lk;
        logic               w_lgt;
        logic [15:0]        w_rh;
        logic signed [15:0] w_rk;
        logic               w_cin;

        if (g == 0) begin : g_first
            assign w_lh  = w_ctl.handle;
            assign w_lk  = w_ctl.key;
            assign w_lgt = 1'b0;
            assign w_cin = 1'b0;
        end else begin : g_mid
            assign w_lh  = w_handle[g-1];
            assign w_lk  = w_key[g-1];
            assign w_lgt = w_gt[g-1];
            assign w_cin = w_carry[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_rh = w_handle[g];
            assign w_rk = w_key[g];
        end else begin : g_inner
            assign w_rh = w_handle[g+1];
            assign w_rk = w_key[g+1];
        end

        srl_cell u_cell (
            .i_clk          (i_clk),
            .i_index        (srl_pkg::IDX_W'(g)),
            .i_ctl          (w_ctl),
            .i_left_handle  (w_lh),
            .i_left_key     (w_lk),
            .i_left_gt      (w_lgt),
            .i_right_handle (w_rh),
            .i_right_key    (w_rk),
            .i_head_handle  (w_handle[0]),
            .i_head_key     (w_key[0]),
            .i_carry        (w_cin),
            .o_handle       (w_handle[g]),
            .o_key          (w_key[g]),
            .o_gt           (w_gt[g]),
            .o_match        (w_match[g]),
            .o_carry        (w_carry[g])
        );
    end

    assign w_any_match = |w_match;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_rd_last   = (r_rd + srl_pkg::CNT_W'(1)) == r_count;

    assign o_in_ready  = (r_state == srl_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer next state, cell control and result build
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_ctl.mode   = srl_pkg::CELL_HOLD;
        w_ctl.handle = r_cmd.handle;
        w_ctl.key    = r_cmd.sort_key;
        w_ctl.count  = r_count;

        case (r_state)
            srl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data;
                    n_rd  = '0;
                    if (i_in_data.operation == srl_pkg::OP_INSERT ||
                        i_in_data.operation == srl_pkg::OP_REMOVE) begin
                        n_state = srl_pkg::S_EXEC;
                    end else if (i_in_data.operation == srl_pkg::OP_READ) begin
                        n_state = srl_pkg::S_READ;
                    end
                end
            end
            srl_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_out.entry_valid  = 1'b0;
                    n_out.entry_handle = '0;
                    n_out.entry_key    = '0;
                    n_out.last         = 1'b1;
                    if (r_cmd.operation == srl_pkg::OP_INSERT) begin
                        if (w_any_match) begin
                            n_out.status = srl_pkg::ST_DUPLICATE;
                        end else if (r_count == srl_pkg::CNT_W'(N)) begin
                            n_out.status = srl_pkg::ST_FULL;
                        end else begin
                            n_out.status = srl_pkg::ST_INSERTED;
                            w_ctl.mode   = srl_pkg::CELL_INSERT;
                            n_count      = r_count + srl_pkg::CNT_W'(1);
                        end
                    end else begin
                        if (w_any_match) begin
                            n_out.status = srl_pkg::ST_REMOVED;
                            w_ctl.mode   = srl_pkg::CELL_REMOVE;
                            n_count      = r_count - srl_pkg::CNT_W'(1);
                        end else begin
                            n_out.status = srl_pkg::ST_NOT_FOUND;
                        end
                    end
                    n_out.entry_count = 6'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = srl_pkg::S_IDLE;
                end
            end
            srl_pkg::S_READ: begin
                if (w_out_free) begin
                    n_out.status      = srl_pkg::ST_INSERTED;
                    n_out.entry_count = 6'(r_count);
                    n_out_valid       = 1'b1;
                    if (r_count == '0) begin
                        n_out.entry_valid  = 1'b0;
                        n_out.entry_handle = '0;
                        n_out.entry_key    = '0;
                        n_out.last         = 1'b1;
                        n_state            = srl_pkg::S_IDLE;
                    end else begin
                        // emit head, rotate the row by one slot
                        n_out.entry_valid  = 1'b1;
                        n_out.entry_handle = w_handle[0];
                        n_out.entry_key    = w_key[0];
                        n_out.last         = w_rd_last;
                        w_ctl.mode         = srl_pkg::CELL_ROTATE;
                        n_rd               = r_rd + srl_pkg::CNT_W'(1);
                        if (w_rd_last) begin
                            n_state = srl_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = srl_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_rd  <= n_rd;
        r_out <= n_out;
    end

    // fill count stays within the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srl_pkg::CNT_W'(N))
        else $error("fill count above capacity");

    // a stored insert grows the list by exactly one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.mode == srl_pkg::CELL_INSERT) |=> (r_count == $past(r_count) + srl_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    // a read-out entry only comes from a non-empty list
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entry_valid) |-> (r_count != '0))
        else $error("entry transfer from an empty list");

    // rotation only while streaming a read-out
    a_rotate_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.mode == srl_pkg::CELL_ROTATE) |-> (r_state == srl_pkg::S_READ && r_count != '0))
        else $error("rotation outside read-out");

endmodule

`default_nettype wire
